[rtl/kfar_pkg.sv]
// Package with the types, codes and step program of the angle/rate Kalman filter.
package kfar_pkg;

    localparam int DATA_W = 32;
    localparam int PC_W   = 6;
    localparam int CFG_IDX_W = 3;

    typedef struct packed {
        logic signed [31:0] measured_angle;
        logic signed [31:0] measured_rate;
    } t_in;

    typedef struct packed {
        logic signed [31:0] angle_estimate_out;
        logic signed [31:0] rate_estimate_out;
        logic               status;
    } t_out;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q00 = 3'd0,
        CFG_Q01 = 3'd1,
        CFG_Q11 = 3'd2,
        CFG_R00 = 3'd3,
        CFG_R01 = 3'd4,
        CFG_R11 = 3'd5,
        CFG_DT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MULWB,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CHK,
        OP_END
    } t_op;

    typedef enum logic [5:0] {
        R_Q00, R_Q01, R_Q11, R_R00, R_R01, R_R11, R_DT, R_ONE,
        R_P00, R_P01, R_P10, R_P11, R_X0, R_X1, R_Z0, R_Z1,
        R_A, R_B, R_T, R_DP,
        R_M00, R_M01, R_M10, R_M11,
        R_S00, R_S01, R_S10, R_S11,
        R_DET, R_K00, R_K01, R_K10, R_K11
    } t_reg;

    typedef struct packed {
        t_op  op;
        t_reg src_a;
        t_reg src_b;
        t_reg dst;
    } t_uop;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

    // Step program of one filter update. The error e1 reuses S11 once it is dead.
    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{OP_END, R_ONE, R_ONE, R_A};
        unique case (pc)
            6'd0:  u = '{OP_MUL, R_DT,  R_P11, R_DP};
            6'd1:  u = '{OP_ADD, R_P10, R_P01, R_T};
            6'd2:  u = '{OP_ADD, R_T,   R_DP,  R_T};
            6'd3:  u = '{OP_MUL, R_DT,  R_T,   R_T};
            6'd4:  u = '{OP_ADD, R_Q00, R_P00, R_M00};
            6'd5:  u = '{OP_ADD, R_M00, R_T,   R_M00};
            6'd6:  u = '{OP_ADD, R_Q01, R_P01, R_M01};
            6'd7:  u = '{OP_ADD, R_M01, R_DP,  R_M01};
            6'd8:  u = '{OP_ADD, R_Q01, R_P10, R_M10};
            6'd9:  u = '{OP_ADD, R_M10, R_DP,  R_M10};
            6'd10: u = '{OP_ADD, R_Q11, R_P11, R_M11};
            6'd11: u = '{OP_ADD, R_M00, R_R00, R_S00};
            6'd12: u = '{OP_ADD, R_M01, R_R01, R_S01};
            6'd13: u = '{OP_ADD, R_M10, R_R01, R_S10};
            6'd14: u = '{OP_ADD, R_M11, R_R11, R_S11};
            6'd15: u = '{OP_MUL, R_S00, R_S11, R_A};
            6'd16: u = '{OP_MUL, R_S01, R_S10, R_B};
            6'd17: u = '{OP_SUB, R_A,   R_B,   R_DET};
            6'd18: u = '{OP_CHK, R_DET, R_DET, R_DET};
            6'd19: u = '{OP_MUL, R_M00, R_S11, R_A};
            6'd20: u = '{OP_MUL, R_M01, R_S10, R_B};
            6'd21: u = '{OP_SUB, R_A,   R_B,   R_A};
            6'd22: u = '{OP_DIV, R_A,   R_DET, R_K00};
            6'd23: u = '{OP_MUL, R_M01, R_R00, R_A};
            6'd24: u = '{OP_MUL, R_M00, R_R01, R_B};
            6'd25: u = '{OP_SUB, R_A,   R_B,   R_A};
            6'd26: u = '{OP_DIV, R_A,   R_DET, R_K01};
            6'd27: u = '{OP_MUL, R_M10, R_R11, R_A};
            6'd28: u = '{OP_MUL, R_M11, R_R01, R_B};
            6'd29: u = '{OP_SUB, R_A,   R_B,   R_A};
            6'd30: u = '{OP_DIV, R_A,   R_DET, R_K10};
            6'd31: u = '{OP_MUL, R_M11, R_S00, R_A};
            6'd32: u = '{OP_MUL, R_M10, R_S01, R_B};
            6'd33: u = '{OP_SUB, R_A,   R_B,   R_A};
            6'd34: u = '{OP_DIV, R_A,   R_DET, R_K11};
            6'd35: u = '{OP_SUB, R_ONE, R_K00, R_T};
            6'd36: u = '{OP_MUL, R_M00, R_T,   R_A};
            6'd37: u = '{OP_MUL, R_K01, R_M10, R_B};
            6'd38: u = '{OP_SUB, R_A,   R_B,   R_P00};
            6'd39: u = '{OP_MUL, R_M01, R_T,   R_A};
            6'd40: u = '{OP_MUL, R_K01, R_M11, R_B};
            6'd41: u = '{OP_SUB, R_A,   R_B,   R_P01};
            6'd42: u = '{OP_SUB, R_ONE, R_K11, R_T};
            6'd43: u = '{OP_MUL, R_M10, R_T,   R_A};
            6'd44: u = '{OP_MUL, R_K10, R_M00, R_B};
            6'd45: u = '{OP_SUB, R_A,   R_B,   R_P10};
            6'd46: u = '{OP_MUL, R_M11, R_T,   R_A};
            6'd47: u = '{OP_MUL, R_K10, R_M01, R_B};
            6'd48: u = '{OP_SUB, R_A,   R_B,   R_P11};
            6'd49: u = '{OP_MUL, R_DT,  R_X1,  R_A};
            6'd50: u = '{OP_ADD, R_X0,  R_A,   R_DP};
            6'd51: u = '{OP_SUB, R_DP,  R_Z0,  R_T};
            6'd52: u = '{OP_SUB, R_X1,  R_Z1,  R_S11};
            6'd53: u = '{OP_MUL, R_K00, R_T,   R_A};
            6'd54: u = '{OP_SUB, R_DP,  R_A,   R_DP};
            6'd55: u = '{OP_MUL, R_K01, R_S11, R_A};
            6'd56: u = '{OP_SUB, R_DP,  R_A,   R_X0};
            6'd57: u = '{OP_MUL, R_K10, R_T,   R_A};
            6'd58: u = '{OP_SUB, R_X1,  R_A,   R_DP};
            6'd59: u = '{OP_MUL, R_K11, R_S11, R_A};
            6'd60: u = '{OP_SUB, R_DP,  R_A,   R_X1};
            default: u = '{OP_END, R_ONE, R_ONE, R_A};
        endcase
        return u;
    endfunction

endpackage

[rtl/kalman_filter_angle_rate.sv]
// Top level of the two-state angle/rate Kalman filter with its step sequencer.
// The filter takes one measured angle and rate per transfer and returns one updated
// angle and rate estimate per transfer, in signed fixed point with FRAC_BITS fraction
// bits; every add, multiply and divide saturates to 32 bits. A 61-step program runs on
// one shared 32x32 multiplier (25 products, each an execute and a writeback step), one
// saturating adder (31 adds and subtracts), a determinant check, a bit-serial divider
// (one divide for each of the four gain terms) and an end step. The input is stalled
// from the input transfer until the result has been taken. When the innovation
// determinant is zero the program stops at the check, status is set and the state and
// covariance are kept.
// Configuration writes are taken at any time but must only be issued while idle.
module kalman_filter_angle_rate #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  kfar_pkg::t_in               i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output kfar_pkg::t_out              o_out_data,
    input  logic                        i_out_stall,
    input  logic                        i_cfg_we,
    input  logic [kfar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                 i_cfg_data
);
    import kfar_pkg::*;

    localparam logic signed [31:0] ONE_VAL = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

    t_state r_state, n_state;
    logic [PC_W-1:0] r_pc;
    t_uop uop;

    // Configuration registers.
    logic [30:0] r_q00, r_q11, r_r00, r_r11;
    logic signed [31:0] r_q01, r_r01;
    logic [16:0] r_dt;

    // Filter state and working registers.
    logic signed [31:0] r_p00, r_p01, r_p10, r_p11, r_x0, r_x1, r_z0, r_z1;
    logic signed [31:0] r_a, r_b, r_t, r_dp;
    logic signed [31:0] r_m00, r_m01, r_m10, r_m11;
    logic signed [31:0] r_s00, r_s01, r_s10, r_s11;
    logic signed [31:0] r_det, r_k00, r_k01, r_k10, r_k11;
    logic signed [63:0] r_prod;
    logic               r_status;

    logic signed [31:0] opa, opb, wb_val;
    logic               wb_en;
    logic signed [32:0] sum;
    logic signed [63:0] rnd;
    logic signed [63:0] mq;
    logic signed [31:0] msat;
    logic               in_xfer, out_xfer;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign uop      = uop_at(r_pc);
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    function automatic logic signed [31:0] read_reg(
        input t_reg code,
        input logic signed [31:0] q00, q01, q11, r00, r01, r11, dt,
        input logic signed [31:0] p00, p01, p10, p11, x0, x1, z0, z1,
        input logic signed [31:0] a, b, t, dp, m00, m01, m10, m11,
        input logic signed [31:0] s00, s01, s10, s11, det, k00, k01, k10, k11
    );
        logic signed [31:0] v;
        v = ONE_VAL;
        case (code)
            R_Q00: v = q00;   R_Q01: v = q01;   R_Q11: v = q11;
            R_R00: v = r00;   R_R01: v = r01;   R_R11: v = r11;
            R_DT:  v = dt;    R_ONE: v = ONE_VAL;
            R_P00: v = p00;   R_P01: v = p01;   R_P10: v = p10;   R_P11: v = p11;
            R_X0:  v = x0;    R_X1:  v = x1;    R_Z0:  v = z0;    R_Z1:  v = z1;
            R_A:   v = a;     R_B:   v = b;     R_T:   v = t;     R_DP:  v = dp;
            R_M00: v = m00;   R_M01: v = m01;   R_M10: v = m10;   R_M11: v = m11;
            R_S00: v = s00;   R_S01: v = s01;   R_S10: v = s10;   R_S11: v = s11;
            R_DET: v = det;   R_K00: v = k00;   R_K01: v = k01;
            R_K10: v = k10;   R_K11: v = k11;
            default: v = ONE_VAL;
        endcase
        return v;
    endfunction

    assign opa = read_reg(uop.src_a, {1'b0, r_q00}, r_q01, {1'b0, r_q11}, {1'b0, r_r00},
        r_r01, {1'b0, r_r11}, {15'd0, r_dt}, r_p00, r_p01, r_p10, r_p11, r_x0, r_x1,
        r_z0, r_z1, r_a, r_b, r_t, r_dp, r_m00, r_m01, r_m10, r_m11,
        r_s00, r_s01, r_s10, r_s11, r_det, r_k00, r_k01, r_k10, r_k11);
    assign opb = read_reg(uop.src_b, {1'b0, r_q00}, r_q01, {1'b0, r_q11}, {1'b0, r_r00},
        r_r01, {1'b0, r_r11}, {15'd0, r_dt}, r_p00, r_p01, r_p10, r_p11, r_x0, r_x1,
        r_z0, r_z1, r_a, r_b, r_t, r_dp, r_m00, r_m01, r_m10, r_m11,
        r_s00, r_s01, r_s10, r_s11, r_det, r_k00, r_k01, r_k10, r_k11);

    // Saturating adder; subtract is the same path with the second operand negated.
    always_comb begin
        if (uop.op == OP_SUB) begin
            sum = 33'(opa) - 33'(opb);
        end else begin
            sum = 33'(opa) + 33'(opb);
        end
    end

    // Product rounding: add half an LSB and floor, which rounds ties toward +infinity.
    assign rnd = r_prod + HALF_LSB;
    assign mq  = rnd >>> FRAC_BITS;
    always_comb begin
        if (mq > 64'sh0000_0000_7FFF_FFFF) begin
            msat = 32'sh7FFF_FFFF;
        end else if (mq < -64'sh0000_0000_8000_0000) begin
            msat = 32'sh8000_0000;
        end else begin
            msat = mq[31:0];
        end
    end

    // Writeback selection.
    always_comb begin
        wb_en  = 1'b0;
        wb_val = msat;
        case (r_state)
            S_EXEC: begin
                if (uop.op == OP_ADD || uop.op == OP_SUB) begin
                    wb_en = 1'b1;
                    if (sum[32] != sum[31]) begin
                        wb_val = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else begin
                        wb_val = sum[31:0];
                    end
                end
            end
            S_MULWB: begin
                wb_en  = 1'b1;
                wb_val = msat;
            end
            S_DIV: begin
                wb_en  = div_rsp.done;
                wb_val = div_rsp.quot;
            end
            default: wb_en = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_EXEC;
            S_EXEC: begin
                unique case (uop.op)
                    OP_MUL: n_state = S_MULWB;
                    OP_DIV: n_state = S_DIV;
                    OP_CHK: if (r_det == '0) n_state = S_OUT;
                    OP_END: n_state = S_OUT;
                    default: n_state = S_EXEC;
                endcase
            end
            S_MULWB: n_state = S_EXEC;
            S_DIV:   if (div_rsp.done) n_state = S_EXEC;
            S_OUT:   if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake and divider control.
    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        o_out_valid   = (r_state == S_OUT);
        div_req.start = (r_state == S_EXEC) && (uop.op == OP_DIV);
        div_req.num   = opa;
        div_req.den   = opb;
    end

    assign o_out_data.angle_estimate_out = r_x0;
    assign o_out_data.rate_estimate_out  = r_x1;
    assign o_out_data.status             = r_status;

    kfar_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_status <= 1'b0;
            r_q00 <= 31'd620626;
            r_q01 <= 32'sd11141;
            r_q11 <= 31'd1671168;
            r_r00 <= 31'd918;
            r_r01 <= 32'sd0;
            r_r11 <= 31'd1311;
            r_dt  <= 17'd655;
            r_x0  <= '0;
            r_x1  <= '0;
            r_p00 <= '0;
            r_p01 <= '0;
            r_p10 <= '0;
            r_p11 <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_Q00: r_q00 <= i_cfg_data[30:0];
                    CFG_Q01: r_q01 <= i_cfg_data;
                    CFG_Q11: r_q11 <= i_cfg_data[30:0];
                    CFG_R00: r_r00 <= i_cfg_data[30:0];
                    CFG_R01: r_r01 <= i_cfg_data;
                    CFG_R11: r_r11 <= i_cfg_data[30:0];
                    CFG_DT:  r_dt  <= i_cfg_data[16:0];
                    default: ;
                endcase
            end

            if (in_xfer) begin
                r_z0 <= i_in_data.measured_angle;
                r_z1 <= i_in_data.measured_rate;
                r_pc <= '0;
            end

            if (r_state == S_EXEC) begin
                if (uop.op == OP_MUL) begin
                    r_prod <= 64'(opa) * 64'(opb);
                end else if (uop.op == OP_ADD || uop.op == OP_SUB) begin
                    r_pc <= r_pc + 1'b1;
                end else if (uop.op == OP_CHK) begin
                    if (r_det == '0) begin
                        r_status <= 1'b1;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end else if (uop.op == OP_END) begin
                    r_status <= 1'b0;
                end
            end
            if (r_state == S_MULWB || (r_state == S_DIV && div_rsp.done)) begin
                r_pc <= r_pc + 1'b1;
            end

            if (wb_en) begin
                case (uop.dst)
                    R_P00: r_p00 <= wb_val;
                    R_P01: r_p01 <= wb_val;
                    R_P10: r_p10 <= wb_val;
                    R_P11: r_p11 <= wb_val;
                    R_X0:  r_x0  <= wb_val;
                    R_X1:  r_x1  <= wb_val;
                    R_A:   r_a   <= wb_val;
                    R_B:   r_b   <= wb_val;
                    R_T:   r_t   <= wb_val;
                    R_DP:  r_dp  <= wb_val;
                    R_M00: r_m00 <= wb_val;
                    R_M01: r_m01 <= wb_val;
                    R_M10: r_m10 <= wb_val;
                    R_M11: r_m11 <= wb_val;
                    R_S00: r_s00 <= wb_val;
                    R_S01: r_s01 <= wb_val;
                    R_S10: r_s10 <= wb_val;
                    R_S11: r_s11 <= wb_val;
                    R_DET: r_det <= wb_val;
                    R_K00: r_k00 <= wb_val;
                    R_K01: r_k01 <= wb_val;
                    R_K10: r_k10 <= wb_val;
                    R_K11: r_k11 <= wb_val;
                    default: ;
                endcase
            end
        end
    end

    // A result never waits while a new input could be taken.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result is pending");

    // An input transfer is never followed directly by a result.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_out_valid)
        else $error("result shown in the cycle after an input transfer");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside of a divide step");

    // A singular update keeps the estimates it had on entry.
    a_singular_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && uop.op == OP_CHK && r_det == '0) |=>
            (o_out_data.status && $stable(r_x0) && $stable(r_x1)))
        else $error("singular update changed the estimates");

endmodule

[rtl/kfar_div.sv]
// Iterative signed fixed-point divider, one quotient bit per cycle, saturating.
module kfar_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kfar_pkg::t_div_req i_req,
    output kfar_pkg::t_div_rsp o_rsp
);
    import kfar_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_dvs;
    logic [31:0] r_q;
    logic        r_neg;
    logic        r_done;
    logic signed [31:0] r_quot;

    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [63:0] dividend;
    logic        ovf;
    logic [32:0] trial;
    logic [31:0] q_next;

    assign mag_n    = i_req.num[31] ? 32'(-i_req.num) : i_req.num;
    assign mag_d    = i_req.den[31] ? 32'(-i_req.den) : i_req.den;
    assign dividend = {32'd0, mag_n} << FRAC_BITS;
    assign ovf      = dividend >= {mag_d, 32'd0};
    assign trial    = {r_rem, r_low[31]} - {1'b0, r_dvs};
    assign q_next   = {r_q[30:0], ~trial[32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg <= i_req.num[31] ^ i_req.den[31];
                r_dvs <= mag_d;
                r_rem <= dividend[63:32];
                r_low <= dividend[31:0];
                r_q   <= '0;
                r_cnt <= 6'd32;
                if (ovf) begin
                    r_done <= 1'b1;
                    r_quot <= (i_req.num[31] ^ i_req.den[31]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= trial[32] ? {r_rem[30:0], r_low[31]} : trial[31:0];
                r_low <= {r_low[30:0], 1'b0};
                r_q   <= q_next;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (!r_neg) begin
                        r_quot <= q_next[31] ? 32'sh7FFF_FFFF : q_next;
                    end else if (q_next[31] && (q_next[30:0] != '0)) begin
                        r_quot <= 32'sh8000_0000;
                    end else begin
                        r_quot <= 32'(-q_next);
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule
